FILE: design/xnir_pkg.sv
// ----------------------------------------------------------------------------
// xnir_pkg: shared types and constants of the next-instruction resolver
// Opcode bytes, flag bit positions, route codes and the decoded item record.
// ----------------------------------------------------------------------------
package xnir_pkg;

	// Primary opcode bytes.
	localparam logic [7:0] OP_RET       = 8'hC3;
	localparam logic [7:0] OP_RET_IMM   = 8'hC2;
	localparam logic [7:0] OP_JMP_SHORT = 8'hEB;
	localparam logic [7:0] OP_JMP_NEAR  = 8'hE9;
	localparam logic [7:0] OP_CALL_NEAR = 8'hE8;
	localparam logic [7:0] OP_GRP_FF    = 8'hFF;
	localparam logic [7:0] OP_JCC_FIRST = 8'h70;
	localparam logic [7:0] OP_JCC_LAST  = 8'h7F;
	localparam logic [7:0] OP_ESCAPE    = 8'h0F;
	localparam logic [7:0] OP_JRCXZ     = 8'hE3;

	// Second opcode bytes after the escape.
	localparam logic [7:0] OP2_JCC_FIRST = 8'h80;
	localparam logic [7:0] OP2_JCC_LAST  = 8'h8F;

	// FF group reg field values that branch.
	localparam logic [2:0] FF_REG_CALL = 3'd2;
	localparam logic [2:0] FF_REG_JMP  = 3'd4;

	// ModRM mod and rm codes.
	localparam logic [1:0] MOD_INDIRECT = 2'd0;
	localparam logic [1:0] MOD_REGISTER = 2'd3;
	localparam logic [2:0] RM_RIP_REL   = 3'd5;

	// Flag bit positions in the low flags word.
	localparam int unsigned FLAG_CF = 0;
	localparam int unsigned FLAG_PF = 2;
	localparam int unsigned FLAG_ZF = 6;
	localparam int unsigned FLAG_SF = 7;
	localparam int unsigned FLAG_OF = 11;

	// Condition groups, taken from bits 3:1 of the condition code.
	localparam logic [2:0] CC_O  = 3'd0;
	localparam logic [2:0] CC_B  = 3'd1;
	localparam logic [2:0] CC_Z  = 3'd2;
	localparam logic [2:0] CC_BE = 3'd3;
	localparam logic [2:0] CC_S  = 3'd4;
	localparam logic [2:0] CC_P  = 3'd5;
	localparam logic [2:0] CC_L  = 3'd6;
	localparam logic [2:0] CC_LE = 3'd7;

	typedef enum logic [2:0] {
		ROUTE_FALL      = 3'd0,
		ROUTE_TAKEN     = 3'd1,
		ROUTE_NOT_TAKEN = 3'd2,
		ROUTE_REG       = 3'd3,
		ROUTE_MEM       = 3'd4
	} route_t;

	// One decoded instruction as held in the input register.
	typedef struct packed {
		logic [63:0] current_pc;
		logic [3:0]  insn_length;
		logic [7:0]  opcode;
		logic [7:0]  second_opcode;
		logic [7:0]  modrm_byte;
		logic        address_size_override;
		logic [31:0] branch_offset;
		logic [11:0] flag_bits;
		logic [63:0] count_register;
		logic [63:0] register_value;
		logic [63:0] loaded_value;
	} insn_t;

	// The resolved result.
	typedef struct packed {
		logic [63:0] next_pc;
		logic [63:0] load_address;
		logic        uses_load;
		route_t      route;
	} result_t;

endpackage

FILE: design/xnir_cond.sv
// ----------------------------------------------------------------------------
// xnir_cond: condition code evaluation
// Decides whether a conditional jump's condition holds for the given flags.
// ----------------------------------------------------------------------------
module xnir_cond (
	input  logic [3:0]  cc,
	input  logic [11:0] flags,
	output logic        holds
);
	import xnir_pkg::*;

	logic cf, pf, zf, sf, of_flag;
	logic base;

	assign cf      = flags[FLAG_CF];
	assign pf      = flags[FLAG_PF];
	assign zf      = flags[FLAG_ZF];
	assign sf      = flags[FLAG_SF];
	assign of_flag = flags[FLAG_OF];

	always_comb begin
		case (cc[3:1])
			CC_O:    base = of_flag;
			CC_B:    base = cf;
			CC_Z:    base = zf;
			CC_BE:   base = cf | zf;
			CC_S:    base = sf;
			CC_P:    base = pf;
			CC_L:    base = sf ^ of_flag;
			CC_LE:   base = zf | (sf ^ of_flag);
			default: base = 1'b0;
		endcase
	end

	// The low bit of the code inverts the condition.
	assign holds = base ^ cc[0];

endmodule

FILE: design/xnir_resolve.sv
// ----------------------------------------------------------------------------
// xnir_resolve: next-address resolution
// Classifies one decoded instruction and forms the next address, the target
// load address and the route code.
// ----------------------------------------------------------------------------
module xnir_resolve (
	input  xnir_pkg::insn_t   insn,
	output xnir_pkg::result_t res
);
	import xnir_pkg::*;

	logic [63:0] seq_pc;
	logic [63:0] off64;
	logic [63:0] rel_pc;
	logic [63:0] base_disp;
	logic [3:0]  cc;
	logic        cc_holds;
	logic        count_zero;
	logic [1:0]  modf;
	logic [2:0]  regf;
	logic [2:0]  rmf;
	logic [63:0] next_pc;
	logic [63:0] load_address;
	route_t      route;

	assign modf = insn.modrm_byte[7:6];
	assign regf = insn.modrm_byte[5:3];
	assign rmf  = insn.modrm_byte[2:0];

	assign off64     = {{32{insn.branch_offset[31]}}, insn.branch_offset};
	assign seq_pc    = insn.current_pc + {60'd0, insn.insn_length};
	assign rel_pc    = seq_pc + off64;
	assign base_disp = insn.register_value + off64;

	// Short conditional jumps carry the code in the opcode, near ones in
	// the byte after the escape.
	assign cc = (insn.opcode == OP_ESCAPE) ? insn.second_opcode[3:0] : insn.opcode[3:0];

	xnir_cond u_cond (
		.cc    (cc),
		.flags (insn.flag_bits),
		.holds (cc_holds)
	);

	assign count_zero = insn.address_size_override ? (insn.count_register[31:0] == 32'd0)
	                                               : (insn.count_register == 64'd0);

	always_comb begin
		next_pc      = seq_pc;
		load_address = 64'd0;
		route        = ROUTE_FALL;
		case (insn.opcode) inside
			OP_RET, OP_RET_IMM: begin
				load_address = insn.register_value;
				route        = ROUTE_MEM;
			end
			OP_JMP_SHORT, OP_JMP_NEAR, OP_CALL_NEAR: begin
				next_pc = rel_pc;
				route   = ROUTE_TAKEN;
			end
			OP_GRP_FF: begin
				if (regf == FF_REG_CALL || regf == FF_REG_JMP) begin
					if (modf == MOD_REGISTER) begin
						next_pc = insn.register_value;
						route   = ROUTE_REG;
					end else begin
						if (modf == MOD_INDIRECT) begin
							load_address = (rmf == RM_RIP_REL) ? rel_pc
							                                   : insn.register_value;
						end else begin
							load_address = base_disp;
						end
						route = ROUTE_MEM;
					end
				end
			end
			[OP_JCC_FIRST:OP_JCC_LAST]: begin
				next_pc = cc_holds ? rel_pc : seq_pc;
				route   = cc_holds ? ROUTE_TAKEN : ROUTE_NOT_TAKEN;
			end
			OP_JRCXZ: begin
				next_pc = count_zero ? rel_pc : seq_pc;
				route   = count_zero ? ROUTE_TAKEN : ROUTE_NOT_TAKEN;
			end
			OP_ESCAPE: begin
				if (insn.second_opcode inside {[OP2_JCC_FIRST:OP2_JCC_LAST]}) begin
					next_pc = cc_holds ? rel_pc : seq_pc;
					route   = cc_holds ? ROUTE_TAKEN : ROUTE_NOT_TAKEN;
				end
			end
			default: begin
				next_pc = seq_pc;
			end
		endcase
		// Returns and memory-indirect branches take the target from memory.
		if (route == ROUTE_MEM) begin
			next_pc = insn.loaded_value;
		end
	end

	assign res.next_pc      = next_pc;
	assign res.load_address = load_address;
	assign res.uses_load    = (route == ROUTE_MEM);
	assign res.route        = route;

endmodule

FILE: design/x86_next_instruction_resolver_top.sv
// ----------------------------------------------------------------------------
// x86_next_instruction_resolver_top: next-instruction address resolver
// Resolves the address of the instruction that follows one decoded x86-64
// instruction, with the memory address read for indirect branches and returns.
// ----------------------------------------------------------------------------
// The block takes one decoded instruction beat in every clock cycle: busy is
// held low, so a beat is accepted at every rising edge at which start is high.
// Each accepted beat produces exactly one result beat, which passes the input
// register and then the result register and is marked by done for a single
// cycle; the receiver cannot stall and must capture the result in that cycle.
// The full decode and the address adders lie between those two registers.
// Results leave in the order in which beats arrived. For a return or a
// memory-indirect jump or call, the caller must present the qword found at the
// resulting load address on loaded_value together with the instruction, since
// the block performs no memory access itself. The block holds no state besides
// its pipeline, and the addresses wrap modulo two to the sixty-fourth power.
// ----------------------------------------------------------------------------
module x86_next_instruction_resolver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] current_pc,
	input  logic [3:0]  insn_length,
	input  logic [7:0]  opcode,
	input  logic [7:0]  second_opcode,
	input  logic [7:0]  modrm_byte,
	input  logic        address_size_override,
	input  logic signed [31:0] branch_offset,
	input  logic [11:0] flag_bits,
	input  logic [63:0] count_register,
	input  logic [63:0] register_value,
	input  logic [63:0] loaded_value,
	output logic        done,
	output logic [63:0] next_pc,
	output logic [63:0] load_address,
	output logic        uses_load,
	output logic [2:0]  route
);
	import xnir_pkg::*;

	logic    accept;
	logic    valid_s1;
	insn_t   insn_s1;
	result_t res_comb;
	logic    done_s2;
	result_t res_s2;

	// The pipeline never fills up, so the block never refuses a beat.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Input register: valid bit under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			insn_s1.current_pc            <= current_pc;
			insn_s1.insn_length           <= insn_length;
			insn_s1.opcode                <= opcode;
			insn_s1.second_opcode         <= second_opcode;
			insn_s1.modrm_byte            <= modrm_byte;
			insn_s1.address_size_override <= address_size_override;
			insn_s1.branch_offset         <= branch_offset;
			insn_s1.flag_bits             <= flag_bits;
			insn_s1.count_register        <= count_register;
			insn_s1.register_value        <= register_value;
			insn_s1.loaded_value          <= loaded_value;
		end
	end

	// Decode, condition evaluation and address arithmetic.
	xnir_resolve u_resolve (
		.insn (insn_s1),
		.res  (res_comb)
	);

	// Result register: the strobe is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign done         = done_s2;
	assign next_pc      = res_s2.next_pc;
	assign load_address = res_s2.load_address;
	assign uses_load    = res_s2.uses_load;
	assign route        = res_s2.route;

`ifndef SYNTH
	// Every accepted beat yields a result through the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done)
		else $error("result strobe missing two cycles after accept");

	// No result appears without a matching accepted beat.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result strobe without a matching accept");

	// The load flag marks exactly the memory route.
	a_load_route: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (uses_load == (route == ROUTE_MEM)))
		else $error("uses_load disagrees with route");

	// Without a load, the load address reads as zero.
	a_load_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !uses_load) |-> (load_address == 64'd0))
		else $error("load address set on a route without a load");
`endif

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the x86-64 next-instruction resolver
// Sends a short table of hand-picked instructions, some with typed-in results,
// then about a thousand random beats weighted toward the branch encodings.
// Every result beat is checked field by field against its typed-in result or an in-bench resolver.
// ----------------------------------------------------------------------------
module tb;
	import xnir_pkg::*;

	localparam int RANDOM_BEATS = 1030;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		insn_t   item;
		bit      typed;
		result_t want;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] current_pc;
	logic [3:0]  insn_length;
	logic [7:0]  opcode;
	logic [7:0]  second_opcode;
	logic [7:0]  modrm_byte;
	logic        address_size_override;
	logic signed [31:0] branch_offset;
	logic [11:0] flag_bits;
	logic [63:0] count_register;
	logic [63:0] register_value;
	logic [63:0] loaded_value;
	logic        done;
	logic [63:0] next_pc;
	logic [63:0] load_address;
	logic        uses_load;
	logic [2:0]  route;

	result_t   pending_targets[$];
	step_row_t directed_steps[$];
	int        mismatches;
	int        cycles;
	int        burst_left;

	x86_next_instruction_resolver_top dut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Evaluates one of the sixteen condition codes against the flags word.
	function automatic bit condition_holds(logic [3:0] cc, logic [11:0] fl);
		bit holds;
		unique case (cc[3:1])
			CC_O:    holds = fl[FLAG_OF];
			CC_B:    holds = fl[FLAG_CF];
			CC_Z:    holds = fl[FLAG_ZF];
			CC_BE:   holds = fl[FLAG_CF] | fl[FLAG_ZF];
			CC_S:    holds = fl[FLAG_SF];
			CC_P:    holds = fl[FLAG_PF];
			CC_L:    holds = fl[FLAG_SF] ^ fl[FLAG_OF];
			default: holds = fl[FLAG_ZF] | (fl[FLAG_SF] ^ fl[FLAG_OF]);
		endcase
		return cc[0] ? !holds : holds;
	endfunction

	// Works out where execution goes after one decoded instruction.
	function automatic result_t resolve_next(insn_t x);
		result_t     r;
		logic [63:0] seq;
		logic [63:0] rel;
		logic [63:0] cnt;
		logic [1:0]  md;
		logic [2:0]  rg;
		logic [2:0]  rmf;
		rel = {{32{x.branch_offset[31]}}, x.branch_offset};
		seq = x.current_pc + {60'd0, x.insn_length};
		md = x.modrm_byte[7:6];
		rg = x.modrm_byte[5:3];
		rmf = x.modrm_byte[2:0];
		r.next_pc = seq;
		r.load_address = '0;
		r.route = ROUTE_FALL;
		if (x.opcode == OP_RET || x.opcode == OP_RET_IMM) begin
			r.load_address = x.register_value;
			r.route = ROUTE_MEM;
		end else if (x.opcode == OP_JMP_SHORT || x.opcode == OP_JMP_NEAR ||
				x.opcode == OP_CALL_NEAR) begin
			r.next_pc = seq + rel;
			r.route = ROUTE_TAKEN;
		end else if (x.opcode == OP_GRP_FF) begin
			if (rg == FF_REG_CALL || rg == FF_REG_JMP) begin
				if (md == MOD_REGISTER) begin
					r.next_pc = x.register_value;
					r.route = ROUTE_REG;
				end else begin
					if (md == MOD_INDIRECT)
						r.load_address = (rmf == RM_RIP_REL) ? seq + rel : x.register_value;
					else
						r.load_address = x.register_value + rel;
					r.route = ROUTE_MEM;
				end
			end
		end else if (x.opcode >= OP_JCC_FIRST && x.opcode <= OP_JCC_LAST) begin
			r.route = ROUTE_NOT_TAKEN;
			if (condition_holds(x.opcode[3:0], x.flag_bits)) begin
				r.next_pc = seq + rel;
				r.route = ROUTE_TAKEN;
			end
		end else if (x.opcode == OP_JRCXZ) begin
			cnt = x.address_size_override ? {32'd0, x.count_register[31:0]} : x.count_register;
			r.route = ROUTE_NOT_TAKEN;
			if (cnt == '0) begin
				r.next_pc = seq + rel;
				r.route = ROUTE_TAKEN;
			end
		end else if (x.opcode == OP_ESCAPE && x.second_opcode >= OP2_JCC_FIRST &&
				x.second_opcode <= OP2_JCC_LAST) begin
			r.route = ROUTE_NOT_TAKEN;
			if (condition_holds(x.second_opcode[3:0], x.flag_bits)) begin
				r.next_pc = seq + rel;
				r.route = ROUTE_TAKEN;
			end
		end
		if (r.route == ROUTE_MEM)
			r.next_pc = x.loaded_value;
		r.uses_load = (r.route == ROUTE_MEM);
		return r;
	endfunction

	function automatic insn_t mk_insn(logic [63:0] pc, logic [3:0] len, logic [7:0] op,
			logic [7:0] op2, logic [7:0] mrm, logic asz, logic [31:0] off,
			logic [11:0] fl, logic [63:0] rcx, logic [63:0] regv, logic [63:0] ldv);
		insn_t x;
		x.current_pc = pc;
		x.insn_length = len;
		x.opcode = op;
		x.second_opcode = op2;
		x.modrm_byte = mrm;
		x.address_size_override = asz;
		x.branch_offset = off;
		x.flag_bits = fl;
		x.count_register = rcx;
		x.register_value = regv;
		x.loaded_value = ldv;
		return x;
	endfunction

	function automatic result_t mk_res(logic [63:0] npc, logic [63:0] laddr, logic ul,
			route_t rt);
		result_t r;
		r.next_pc = npc;
		r.load_address = laddr;
		r.uses_load = ul;
		r.route = rt;
		return r;
	endfunction

	function automatic logic [63:0] rand_qword();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return '1;
		else if (pick == 2)
			return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 64));
		return {$urandom, $urandom};
	endfunction

	// Random instruction, weighted toward the encodings that branch.
	function automatic insn_t rand_insn();
		insn_t       x;
		int unsigned kind;
		int unsigned pick;
		kind = $urandom_range(0, 99);
		x.current_pc = rand_qword();
		x.insn_length = 4'($urandom_range(0, 15));
		x.second_opcode = 8'($urandom);
		x.modrm_byte = 8'($urandom);
		x.address_size_override = 1'($urandom);
		if ($urandom_range(0, 3) == 0)
			x.branch_offset = 32'(int'($urandom_range(0, 511)) - 256);
		else
			x.branch_offset = $urandom;
		x.flag_bits = 12'($urandom);
		x.count_register = rand_qword();
		x.register_value = rand_qword();
		x.loaded_value = {$urandom, $urandom};
		if (kind < 10) begin
			x.opcode = $urandom_range(0, 1) ? OP_RET : OP_RET_IMM;
		end else if (kind < 25) begin
			pick = $urandom_range(0, 2);
			x.opcode = (pick == 0) ? OP_JMP_SHORT : (pick == 1) ? OP_JMP_NEAR : OP_CALL_NEAR;
		end else if (kind < 45) begin
			x.opcode = OP_GRP_FF;
			if ($urandom_range(0, 4) != 0)
				x.modrm_byte[5:3] = $urandom_range(0, 1) ? FF_REG_CALL : FF_REG_JMP;
		end else if (kind < 65) begin
			x.opcode = OP_JCC_FIRST + 8'($urandom_range(0, 15));
		end else if (kind < 75) begin
			x.opcode = OP_JRCXZ;
			pick = $urandom_range(0, 3);
			if (pick == 0)
				x.count_register = '0;
			else if (pick == 1)
				x.count_register[31:0] = '0;
		end else if (kind < 90) begin
			x.opcode = OP_ESCAPE;
			if ($urandom_range(0, 4) != 0)
				x.second_opcode = OP2_JCC_FIRST + 8'($urandom_range(0, 15));
		end else begin
			x.opcode = 8'($urandom);
		end
		return x;
	endfunction

	task automatic apply_fields(insn_t x);
		current_pc <= x.current_pc;
		insn_length <= x.insn_length;
		opcode <= x.opcode;
		second_opcode <= x.second_opcode;
		modrm_byte <= x.modrm_byte;
		address_size_override <= x.address_size_override;
		branch_offset <= x.branch_offset;
		flag_bits <= x.flag_bits;
		count_register <= x.count_register;
		register_value <= x.register_value;
		loaded_value <= x.loaded_value;
	endtask

	// Presents one beat and holds it until the block takes it.
	task automatic send_beat(insn_t x, result_t want);
		@(negedge clk);
		apply_fields(x);
		start <= 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_targets.push_back(want);
	endtask

	// Idle gap after a beat: usually none or short, sometimes long, with
	// bursts of back-to-back beats. Idle cycles carry junk on the fields.
	task automatic idle_gap();
		int unsigned pick;
		int unsigned gap;
		pick = $urandom_range(0, 99);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if (pick < 3) begin
			burst_left = $urandom_range(20, 60);
			gap = 0;
		end else if (pick < 50) begin
			gap = 0;
		end else if (pick < 90) begin
			gap = $urandom_range(1, 3);
		end else if (pick < 98) begin
			gap = $urandom_range(4, 12);
		end else begin
			gap = $urandom_range(20, 60);
		end
		if (gap != 0) begin
			@(negedge clk);
			start <= 1'b0;
			apply_fields(rand_insn());
			repeat (gap) @(posedge clk);
		end
	endtask

	// Each result beat is held for one cycle only, so it is taken every time
	// done is seen high at a rising edge.
	always @(posedge clk) begin : check_results
		result_t exp;
		if (arst_n && done === 1'b1) begin
			if (pending_targets.size() == 0) begin
				$display("%0t unexpected result beat: next_pc %h route %0d", $time, next_pc,
					route);
				mismatches++;
			end else begin
				exp = pending_targets.pop_front();
				if (next_pc !== exp.next_pc) begin
					$display("%0t next_pc mismatch: expected %h, got %h", $time,
						exp.next_pc, next_pc);
					mismatches++;
				end
				if (load_address !== exp.load_address) begin
					$display("%0t load_address mismatch: expected %h, got %h", $time,
						exp.load_address, load_address);
					mismatches++;
				end
				if (uses_load !== exp.uses_load) begin
					$display("%0t uses_load mismatch: expected %b, got %b", $time,
						exp.uses_load, uses_load);
					mismatches++;
				end
				if (route !== exp.route) begin
					$display("%0t route mismatch: expected %0d, got %0d", $time,
						exp.route, route);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic add_step(insn_t x, bit typed, result_t want);
		step_row_t row;
		row.item = x;
		row.typed = typed;
		row.want = want;
		directed_steps.push_back(row);
	endtask

	task automatic build_directed();
		result_t none;
		none = mk_res('0, '0, 1'b0, ROUTE_FALL);
		// Returns: target comes from the loaded qword, address from the stack pointer.
		add_step(mk_insn(64'h0000_7FF6_1234_5000, 4'd1, OP_RET, 8'h00, 8'h00, 1'b0, 32'h0,
			12'h000, 64'h0, 64'h0000_00E8_FFFF_F8A0, 64'h0000_7FF6_1234_0ABC), 1'b1,
			mk_res(64'h0000_7FF6_1234_0ABC, 64'h0000_00E8_FFFF_F8A0, 1'b1, ROUTE_MEM));
		add_step(mk_insn('1, 4'd3, OP_RET_IMM, 8'hFF, 8'hFF, 1'b1, 32'hFFFF_FFFF,
			12'hFFF, '1, '1, '0), 1'b1, mk_res('0, '1, 1'b1, ROUTE_MEM));
		// Relative jumps and calls with wrapping at both ends of the address space.
		add_step(mk_insn(64'hFFFF_FFFF_FFFF_FFF0, 4'd2, OP_JMP_SHORT, 8'h00, 8'h00, 1'b0,
			32'hFFFF_FFFF, 12'h000, 64'h0, 64'h0, 64'h0), 1'b1,
			mk_res(64'hFFFF_FFFF_FFFF_FFF1, '0, 1'b0, ROUTE_TAKEN));
		add_step(mk_insn('1, 4'd15, OP_JMP_NEAR, 8'h00, 8'h00, 1'b0, 32'h7FFF_FFFF,
			12'h000, 64'h0, 64'h0, 64'h0), 1'b1,
			mk_res(64'h0000_0000_8000_000D, '0, 1'b0, ROUTE_TAKEN));
		add_step(mk_insn('0, 4'd5, OP_CALL_NEAR, 8'h00, 8'h00, 1'b0, 32'h8000_0000,
			12'h000, 64'h0, 64'h0, 64'h0), 1'b1,
			mk_res(64'hFFFF_FFFF_8000_0005, '0, 1'b0, ROUTE_TAKEN));
		// FF group: register target, then each memory form.
		add_step(mk_insn(64'h1000, 4'd2, OP_GRP_FF, 8'h00, 8'hD0, 1'b0, 32'h0, 12'h000,
			64'h0, 64'hDEAD_BEEF_0123_4567, 64'h5555), 1'b1,
			mk_res(64'hDEAD_BEEF_0123_4567, '0, 1'b0, ROUTE_REG));
		add_step(mk_insn(64'h2000, 4'd3, OP_GRP_FF, 8'h00, 8'hE7, 1'b0, 32'h10, 12'h000,
			64'h0, 64'h1234_5678_9ABC_DEF0, 64'h0), 1'b0, none);
		add_step(mk_insn(64'h0000_7FF0_0000_1000, 4'd6, OP_GRP_FF, 8'h00, 8'h25, 1'b0,
			32'h0000_2000, 12'h000, 64'h0, 64'h9999, 64'h0000_7FF0_AAAA_0000), 1'b0, none);
		add_step(mk_insn(64'h3000, 4'd2, OP_GRP_FF, 8'h00, 8'h10, 1'b0, 32'h44, 12'h000,
			64'h0, 64'h0000_0010_0000_0000, 64'hCAFE), 1'b0, none);
		add_step(mk_insn(64'h3000, 4'd3, OP_GRP_FF, 8'h00, 8'h14, 1'b0, 32'h44, 12'h000,
			64'h0, 64'h0000_0020_0000_0000, 64'hBEEF), 1'b0, none);
		add_step(mk_insn(64'h4000, 4'd4, OP_GRP_FF, 8'h00, 8'h64, 1'b0, 32'hFFFF_FF80,
			12'h000, 64'h0, 64'h0000_0000_0000_0040, 64'hF00D), 1'b0, none);
		add_step(mk_insn(64'h4000, 4'd7, OP_GRP_FF, 8'h00, 8'h93, 1'b0, 32'h7FFF_FFFF,
			12'h000, 64'h0, '1, 64'h1), 1'b0, none);
		// FF group members that do not branch fall through.
		add_step(mk_insn(64'h1000, 4'd6, OP_GRP_FF, 8'h00, 8'h05, 1'b0, 32'h100, 12'h000,
			64'h0, 64'h7777, 64'h8888), 1'b1, mk_res(64'h1006, '0, 1'b0, ROUTE_FALL));
		add_step(mk_insn(64'h1000, 4'd2, OP_GRP_FF, 8'h00, 8'hF0, 1'b0, 32'h100, 12'h000,
			64'h0, 64'h7777, 64'h8888), 1'b0, none);
		// Escaped opcode outside the conditional jump range falls through.
		add_step(mk_insn(64'h2000, 4'd2, OP_ESCAPE, 8'h05, 8'h00, 1'b0, 32'h40, 12'hFFF,
			64'h0, 64'h0, 64'h0), 1'b1, mk_res(64'h2002, '0, 1'b0, ROUTE_FALL));
		add_step(mk_insn(64'h2000, 4'd3, OP_ESCAPE, 8'h90, 8'h00, 1'b0, 32'h40, 12'hFFF,
			64'h0, 64'h0, 64'h0), 1'b0, none);
		// Conditional jumps, near and short, taken and not taken.
		add_step(mk_insn(64'h5000, 4'd6, OP_ESCAPE, OP2_JCC_FIRST, 8'h00, 1'b0, 32'h1000,
			12'h800, 64'h0, 64'h0, 64'h0), 1'b0, none);
		add_step(mk_insn(64'h5000, 4'd6, OP_ESCAPE, OP2_JCC_LAST, 8'h00, 1'b0, 32'hFFFF_F000,
			12'h000, 64'h0, 64'h0, 64'h0), 1'b0, none);
		add_step(mk_insn(64'h6000, 4'd2, 8'h74, 8'h00, 8'h00, 1'b0, 32'h20, 12'h040,
			64'h0, 64'h0, 64'h0), 1'b0, none);
		add_step(mk_insn(64'h6000, 4'd2, 8'h75, 8'h00, 8'h00, 1'b0, 32'h20, 12'h040,
			64'h0, 64'h0, 64'h0), 1'b0, none);
		add_step(mk_insn(64'h6000, 4'd2, 8'h7C, 8'h00, 8'h00, 1'b0, 32'hFFFF_FFE0, 12'h080,
			64'h0, 64'h0, 64'h0), 1'b0, none);
		// JRCXZ: zero full count, the 32-bit count with the upper half set, then that value as a full count.
		add_step(mk_insn(64'h7000, 4'd2, OP_JRCXZ, 8'h00, 8'h00, 1'b0, 32'h10, 12'h000,
			64'h0, 64'h0, 64'h0), 1'b0, none);
		add_step(mk_insn(64'h7000, 4'd3, OP_JRCXZ, 8'h00, 8'h00, 1'b1, 32'h10, 12'h000,
			64'hFFFF_FFFF_0000_0000, 64'h0, 64'h0), 1'b0, none);
		add_step(mk_insn(64'h7000, 4'd2, OP_JRCXZ, 8'h00, 8'h00, 1'b0, 32'h10, 12'h000,
			64'hFFFF_FFFF_0000_0000, 64'h0, 64'h0), 1'b0, none);
		// A zero length is used as given.
		add_step(mk_insn(64'h3000, 4'd0, 8'h90, 8'h00, 8'h00, 1'b0, 32'h0, 12'h000,
			64'h0, 64'h0, 64'h0), 1'b1, mk_res(64'h3000, '0, 1'b0, ROUTE_FALL));
	endtask

	initial begin
		insn_t   x;
		result_t want;
		mismatches = 0;
		cycles = 0;
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		current_pc = '0;
		insn_length = '0;
		opcode = '0;
		second_opcode = '0;
		modrm_byte = '0;
		address_size_override = 1'b0;
		branch_offset = '0;
		flag_bits = '0;
		count_register = '0;
		register_value = '0;
		loaded_value = '0;
		build_directed();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < directed_steps.size(); i++) begin
			if (directed_steps[i].typed)
				want = directed_steps[i].want;
			else
				want = resolve_next(directed_steps[i].item);
			send_beat(directed_steps[i].item, want);
			idle_gap();
		end

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			x = rand_insn();
			send_beat(x, resolve_next(x));
			idle_gap();
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_targets.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
